// ----- hdl/balance_robot_motor_mixer_defines.svh -----
// Assertion macros for the motor mixer block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BALANCE_ROBOT_MOTOR_MIXER_DEFINES_SVH
`define BALANCE_ROBOT_MOTOR_MIXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define BMM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define BMM_ASSERT(lbl, clk, rst_n, prop)
`define BMM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- hdl/bmm_pkg.sv -----
// Shared types and constants of the motor mixer block.
// No dependencies; imported by every module of the block.
package bmm_pkg;

  localparam logic signed [15:0] ANGLE_TARGET_RST     = 16'sd256;
  localparam logic signed [23:0] ANGLE_PROP_GAIN_RST  = 24'sd184320;
  localparam logic signed [23:0] ANGLE_DERIV_GAIN_RST = 24'sd435;
  localparam logic signed [15:0] SPEED_TARGET_RST     = 16'sd0;
  localparam logic signed [23:0] SPEED_PROP_GAIN_RST  = -24'sd35840;
  localparam logic signed [23:0] SPEED_INTEG_GAIN_RST = -24'sd179;
  localparam logic signed [23:0] YAW_DERIV_GAIN_RST   = 24'sd0;

  // ceil(2^22 / 5): exact quotient by five for magnitudes below 2^22
  localparam logic signed [23:0] RECIP5    = 24'sd838861;
  localparam int unsigned        RECIP5_SH = 22;
  localparam logic signed [18:0] SUM_LIMIT = 19'sd10000;

  typedef enum logic [2:0] {
    CFG_ANGLE_TARGET     = 3'd0,
    CFG_ANGLE_PROP_GAIN  = 3'd1,
    CFG_ANGLE_DERIV_GAIN = 3'd2,
    CFG_SPEED_TARGET     = 3'd3,
    CFG_SPEED_PROP_GAIN  = 3'd4,
    CFG_SPEED_INTEG_GAIN = 3'd5,
    CFG_YAW_DERIV_GAIN   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_DIV = 3'd0,
    OP_ANG = 3'd1,
    OP_PIT = 3'd2,
    OP_SPD = 3'd3,
    OP_INT = 3'd4,
    OP_YAW = 3'd5
  } op_e;

  typedef struct packed {
    logic signed [15:0] angle_target;
    logic signed [23:0] angle_prop_gain;
    logic signed [23:0] angle_deriv_gain;
    logic signed [15:0] speed_target;
    logic signed [23:0] speed_prop_gain;
    logic signed [23:0] speed_integ_gain;
    logic signed [23:0] yaw_deriv_gain;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul;
    logic post;
    op_e  op;
    logic mix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

// ----- hdl/bmm_cfg_regs.sv -----
// Configuration register bank of the motor mixer block.
// Depends on bmm_pkg for the register map and reset values.
module bmm_cfg_regs import bmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_target     <= ANGLE_TARGET_RST;
      cfg_q.angle_prop_gain  <= ANGLE_PROP_GAIN_RST;
      cfg_q.angle_deriv_gain <= ANGLE_DERIV_GAIN_RST;
      cfg_q.speed_target     <= SPEED_TARGET_RST;
      cfg_q.speed_prop_gain  <= SPEED_PROP_GAIN_RST;
      cfg_q.speed_integ_gain <= SPEED_INTEG_GAIN_RST;
      cfg_q.yaw_deriv_gain   <= YAW_DERIV_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ANGLE_TARGET:     cfg_q.angle_target     <= cfg_data_i[15:0];
        CFG_ANGLE_PROP_GAIN:  cfg_q.angle_prop_gain  <= cfg_data_i;
        CFG_ANGLE_DERIV_GAIN: cfg_q.angle_deriv_gain <= cfg_data_i;
        CFG_SPEED_TARGET:     cfg_q.speed_target     <= cfg_data_i[15:0];
        CFG_SPEED_PROP_GAIN:  cfg_q.speed_prop_gain  <= cfg_data_i;
        CFG_SPEED_INTEG_GAIN: cfg_q.speed_integ_gain <= cfg_data_i;
        CFG_YAW_DERIV_GAIN:   cfg_q.yaw_deriv_gain   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/bmm_datapath.sv -----
// Datapath of the motor mixer: speed filter and integral, one shared
// multiplier, term registers and the output register. Depends on bmm_pkg.
`include "balance_robot_motor_mixer_defines.svh"
module bmm_datapath import bmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  cfg_t        cfg_i,
  input  logic [15:0] tilt_angle_i,
  input  logic [15:0] pitch_rate_i,
  input  logic [15:0] yaw_rate_i,
  input  logic [15:0] left_count_i,
  input  logic [15:0] right_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_drive_o,
  output logic [15:0] right_drive_o
);

  function automatic logic signed [15:0] sat16(input logic signed [42:0] x);
    if (x > 43'sd32767) begin
      return 16'sh7fff;
    end else if (x < -43'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

  logic signed [15:0] tilt_q, pitch_q, yaw_q, lcnt_q, rcnt_q;
  logic signed [16:0] diff_q;
  logic        [17:0] num_mag_q;
  logic               num_neg_q;
  logic signed [15:0] filt_q, filt_d;
  logic signed [14:0] sum_q, sum_d;
  logic signed [42:0] prod_q;
  logic signed [15:0] ang_t_q, pit_t_q, spd_t_q, int_t_q, yaw_t_q;
  logic signed [15:0] angle_q, speed_q;
  logic signed [15:0] left_q, right_q;
  logic               out_valid_q, out_valid_d;

  logic signed [17:0] err_w;
  logic signed [18:0] num_w, num_abs_w, sum_w;
  logic signed [16:0] diff_w;
  logic signed [18:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [42:0] bias_w, biased_w, shifted_w, term_w;
  logic        [20:0] quo_w;
  logic signed [21:0] fq_w;
  logic signed [15:0] term_sat_w;

  // speed error, filter numerator, clamped integral and angle error
  always_comb begin
    err_w     = 18'(cfg_i.speed_target) - (18'(rcnt_q) - 18'(lcnt_q));
    num_w     = 19'(err_w) + (19'(filt_q) <<< 2);
    num_abs_w = num_w[18] ? -num_w : num_w;
    sum_w     = 19'(sum_q) + 19'(err_w);
    diff_w    = 17'(cfg_i.angle_target) - 17'(tilt_q);
    if (sum_w > SUM_LIMIT) begin
      sum_d = SUM_LIMIT[14:0];
    end else if (sum_w < -SUM_LIMIT) begin
      sum_d = 15'(-SUM_LIMIT);
    end else begin
      sum_d = sum_w[14:0];
    end
  end

  // operand select of the shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_DIV: begin
        mul_a = {1'b0, num_mag_q};
        mul_b = RECIP5;
      end
      OP_ANG: begin
        mul_a = 19'(diff_q);
        mul_b = cfg_i.angle_prop_gain;
      end
      OP_PIT: begin
        mul_a = 19'(pitch_q);
        mul_b = cfg_i.angle_deriv_gain;
      end
      OP_SPD: begin
        mul_a = 19'(filt_q);
        mul_b = cfg_i.speed_prop_gain;
      end
      OP_INT: begin
        mul_a = 19'(sum_q);
        mul_b = cfg_i.speed_integ_gain;
      end
      OP_YAW: begin
        mul_a = 19'(yaw_q);
        mul_b = cfg_i.yaw_deriv_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // truncate toward zero, then saturate
  always_comb begin
    if (prod_q[42]) begin
      bias_w = (cmd_i.op == OP_ANG) ? 43'sd65535 : 43'sd255;
    end else begin
      bias_w = '0;
    end
    biased_w  = prod_q + bias_w;
    shifted_w = (cmd_i.op == OP_ANG) ? (biased_w >>> 16) : (biased_w >>> 8);
    quo_w     = prod_q[42:RECIP5_SH];
    fq_w      = num_neg_q ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
    term_w    = (cmd_i.op == OP_DIV) ? 43'(fq_w) : shifted_w;
    term_sat_w = sat16(term_w);
  end

  always_comb begin
    filt_d = filt_q;
    if (cmd_i.post && (cmd_i.op == OP_DIV)) begin
      filt_d = term_sat_w;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      filt_q      <= filt_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.prep) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tilt_q  <= tilt_angle_i;
      pitch_q <= pitch_rate_i;
      yaw_q   <= yaw_rate_i;
      lcnt_q  <= left_count_i;
      rcnt_q  <= right_count_i;
    end
    if (cmd_i.prep) begin
      diff_q    <= diff_w;
      num_mag_q <= num_abs_w[17:0];
      num_neg_q <= num_w[18];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.post) begin
      case (cmd_i.op)
        OP_ANG:  ang_t_q <= term_sat_w;
        OP_PIT:  pit_t_q <= term_sat_w;
        OP_SPD:  spd_t_q <= term_sat_w;
        OP_INT:  int_t_q <= term_sat_w;
        OP_YAW:  yaw_t_q <= term_sat_w;
        default: begin
        end
      endcase
    end
    if (cmd_i.mix) begin
      angle_q <= sat16(43'(ang_t_q) + 43'(pit_t_q));
      speed_q <= sat16(43'(spd_t_q) + 43'(int_t_q));
    end
    if (cmd_i.load_out) begin
      left_q  <= sat16(43'(angle_q) + 43'(speed_q) + 43'(yaw_t_q));
      right_q <= sat16(43'(angle_q) + 43'(speed_q) - 43'(yaw_t_q));
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign left_drive_o      = left_q;
  assign right_drive_o     = right_q;

  `BMM_ASSERT(a_sum_in_range, clk_i, rst_ni, (sum_q <= 15'sd10000) && (sum_q >= -15'sd10000))
  `BMM_ASSERT(a_load_shows, clk_i, rst_ni, cmd_i.load_out |=> out_valid_o)

endmodule

// ----- hdl/bmm_ctrl.sv -----
// Sequencer of the motor mixer: steps the shared multiplier through the
// filter quotient and the five gain products. Depends on bmm_pkg.
`include "balance_robot_motor_mixer_defines.svh"
module bmm_ctrl import bmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_POST = 6'b001000,
    ST_MIX  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  function automatic op_e next_op(input op_e op);
    case (op)
      OP_DIV:  return OP_ANG;
      OP_ANG:  return OP_PIT;
      OP_PIT:  return OP_SPD;
      OP_SPD:  return OP_INT;
      OP_INT:  return OP_YAW;
      default: return OP_DIV;
    endcase
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        op_d       = OP_DIV;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_POST;
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        if (op_q == OP_YAW) begin
          state_d = ST_MIX;
        end else begin
          op_d    = next_op(op_q);
          state_d = ST_MUL;
        end
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_DIV;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `BMM_ASSERT(a_accept_prep, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == ST_PREP))
  `BMM_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load_out |-> !sts_i.out_blocked)
  `BMM_ASSERT(a_yaw_last, clk_i, rst_ni, (cmd_o.post && (cmd_o.op == OP_YAW)) |=> cmd_o.mix)

endmodule

// ----- hdl/balance_robot_motor_mixer.sv -----
// Motor mixer of a two-wheel balancing robot: angle PD, speed PI, turn D.
// Top level; depends on bmm_pkg, bmm_cfg_regs, bmm_ctrl and bmm_datapath.
//
// Input channel (in_valid_i / in_stall_o) takes one control tick: tilt
// angle, pitch and yaw rates and both encoder counts. Output channel
// (out_valid_o / out_stall_i) returns one left/right drive request per
// tick. Config channel writes registers 0..6 by index; unused indices
// are dropped. Write only while the block is idle.
// From input accept to output valid the sequencer runs one prepare step,
// six multiply/scale pairs on the one shared 19x24 multiplier
// (filter quotient by reciprocal, then five gain products), one mix
// step and the output load. A new tick is taken only from idle.
// The output register parts the sides: the next tick is accepted while a
// drive request waits; if it still waits when the next one is ready the
// sequencer holds before the output load.
// Reset clears the speed filter, the integral and all valid flags, and
// loads the default gains.
module balance_robot_motor_mixer import bmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] tilt_angle_i,
  input  logic [15:0] pitch_rate_i,
  input  logic [15:0] yaw_rate_i,
  input  logic [15:0] left_count_i,
  input  logic [15:0] right_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_drive_o,
  output logic [15:0] right_drive_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bmm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .tilt_angle_i  (tilt_angle_i),
    .pitch_rate_i  (pitch_rate_i),
    .yaw_rate_i    (yaw_rate_i),
    .left_count_i  (left_count_i),
    .right_count_i (right_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o)
  );

endmodule

// ----- bench/bmm_drive_checker.sv -----
`timescale 1ns / 100ps
// Checker for the motor mixer: mirrors the gain registers and the speed loop
// state, predicts the drive request of every accepted tick and compares it.
// Depends on bmm_pkg for the register indexes and reset values.
module bmm_drive_checker import bmm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [15:0]        tilt_angle_i,
  input  logic [15:0]        pitch_rate_i,
  input  logic [15:0]        yaw_rate_i,
  input  logic [15:0]        left_count_i,
  input  logic [15:0]        right_count_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [15:0]        left_drive_i,
  input  logic [15:0]        right_drive_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_count_o,
  output int unsigned        checked_count_o
);

  localparam longint INTEG_LIMIT = 10000;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } drive_t;

  logic signed [15:0] tgt_angle;
  logic signed [23:0] kp_angle;
  logic signed [23:0] kd_angle;
  logic signed [15:0] tgt_speed;
  logic signed [23:0] kp_speed;
  logic signed [23:0] ki_speed;
  logic signed [23:0] kd_yaw;
  logic signed [15:0] filt_err;
  logic signed [14:0] err_sum;

  drive_t drive_q[$];
  drive_t want;

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint gain_term(longint a, longint g, longint div);
    return clip16((a * g) / div);
  endfunction

  function automatic drive_t predict_drive(logic [15:0] tilt, logic [15:0] pitch,
                                           logic [15:0] yaw, logic [15:0] lcnt,
                                           logic [15:0] rcnt);
    longint angle;
    longint speed;
    longint turn;
    longint err;
    longint isum;
    drive_t d;
    angle = clip16(gain_term(longint'(tgt_angle) - longint'($signed(tilt)),
                             longint'(kp_angle), 65536)
                 + gain_term(longint'($signed(pitch)), longint'(kd_angle), 256));
    err = longint'(tgt_speed) - (longint'($signed(rcnt)) - longint'($signed(lcnt)));
    filt_err = 16'(clip16((err + 4 * longint'(filt_err)) / 5));
    isum = longint'(err_sum) + err;
    if (isum > INTEG_LIMIT) isum = INTEG_LIMIT;
    if (isum < -INTEG_LIMIT) isum = -INTEG_LIMIT;
    err_sum = 15'(isum);
    speed = clip16(gain_term(longint'(filt_err), longint'(kp_speed), 256)
                 + gain_term(longint'(err_sum), longint'(ki_speed), 256));
    turn = gain_term(longint'($signed(yaw)), longint'(kd_yaw), 256);
    d.left  = 16'(clip16(angle + speed + turn));
    d.right = 16'(clip16(angle + speed - turn));
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_angle = ANGLE_TARGET_RST;
      kp_angle = ANGLE_PROP_GAIN_RST;
      kd_angle = ANGLE_DERIV_GAIN_RST;
      tgt_speed = SPEED_TARGET_RST;
      kp_speed = SPEED_PROP_GAIN_RST;
      ki_speed = SPEED_INTEG_GAIN_RST;
      kd_yaw = YAW_DERIV_GAIN_RST;
      filt_err = '0;
      err_sum = '0;
      drive_q.delete();
      mismatch_count_o = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ANGLE_TARGET:     tgt_angle = cfg_data_i[15:0];
          CFG_ANGLE_PROP_GAIN:  kp_angle = cfg_data_i;
          CFG_ANGLE_DERIV_GAIN: kd_angle = cfg_data_i;
          CFG_SPEED_TARGET:     tgt_speed = cfg_data_i[15:0];
          CFG_SPEED_PROP_GAIN:  kp_speed = cfg_data_i;
          CFG_SPEED_INTEG_GAIN: ki_speed = cfg_data_i;
          CFG_YAW_DERIV_GAIN:   kd_yaw = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        drive_q.push_back(predict_drive(tilt_angle_i, pitch_rate_i, yaw_rate_i,
                                        left_count_i, right_count_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $error("unexpected drive request: left_drive %0d, right_drive %0d",
                 $signed(left_drive_i), $signed(right_drive_i));
          mismatch_count_o++;
        end else begin
          want = drive_q.pop_front();
          checked_count_o++;
          if (left_drive_i !== want.left) begin
            $error("left_drive: expected %0d, got %0d",
                   $signed(want.left), $signed(left_drive_i));
            mismatch_count_o++;
          end
          if (right_drive_i !== want.right) begin
            $error("right_drive: expected %0d, got %0d",
                   $signed(want.right), $signed(right_drive_i));
            mismatch_count_o++;
          end
        end
      end
    end
    pending_count_o = drive_q.size();
  end

endmodule

// ----- bench/balance_robot_motor_mixer_tb.sv -----
`timescale 1ns / 100ps
// Top of the motor mixer bench: clock, reset, tick and register stimulus,
// receiver stalls and the verdict. Depends on bmm_pkg, the block and
// bmm_drive_checker.
module balance_robot_motor_mixer_tb;
  import bmm_pkg::*;

  localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
  localparam int         QUIET_LIMIT    = 2000;
  localparam int         SEG_TICKS      = 138;

  typedef struct packed {
    logic [15:0] tilt;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] lcnt;
    logic [15:0] rcnt;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] tilt = '0;
  logic [15:0] pitch = '0;
  logic [15:0] yaw = '0;
  logic [15:0] lcnt = '0;
  logic [15:0] rcnt = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] left_drive;
  logic [15:0] right_drive;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned ticks_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  balance_robot_motor_mixer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .tilt_angle_i  (tilt),
    .pitch_rate_i  (pitch),
    .yaw_rate_i    (yaw),
    .left_count_i  (lcnt),
    .right_count_i (rcnt),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bmm_drive_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .tilt_angle_i     (tilt),
    .pitch_rate_i     (pitch),
    .yaw_rate_i       (yaw),
    .left_count_i     (lcnt),
    .right_count_i    (rcnt),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .left_drive_i     (left_drive),
    .right_drive_i    (right_drive),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("balance_robot_motor_mixer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t mk(logic [15:0] t, logic [15:0] p, logic [15:0] y,
                               logic [15:0] l, logic [15:0] r);
    tick_t k;
    k.tilt = t;
    k.pitch = p;
    k.yaw = y;
    k.lcnt = l;
    k.rcnt = r;
    return k;
  endfunction

  function automatic logic [15:0] near16(int mag);
    return 16'(int'($urandom_range(2 * mag)) - mag);
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(3))
      0:       return 24'($urandom);
      1:       return 24'(int'($urandom_range(1024)) - 512);
      2:       return 24'(int'($urandom_range(16384)) - 8192);
      default: return 24'(int'($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic [15:0] rand_target();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return near16(512);
  endfunction

  function automatic tick_t rand_tick();
    if ($urandom_range(3) == 0)
      return mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    return mk(near16(2048), near16(1024), near16(1024), near16(64), near16(64));
  endfunction

  task automatic send_tick(tick_t k);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    {tilt, pitch, yaw, lcnt, rcnt} = k;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    @(negedge clk);
  endtask

  // hold off until every drive request is back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_gains(logic [15:0] at, logic [23:0] kpa, logic [23:0] kda,
                           logic [15:0] st, logic [23:0] kps, logic [23:0] kis,
                           logic [23:0] kdy);
    write_reg(CFG_ANGLE_TARGET, {8'($urandom), at});
    write_reg(CFG_ANGLE_PROP_GAIN, kpa);
    write_reg(CFG_ANGLE_DERIV_GAIN, kda);
    write_reg(CFG_SPEED_TARGET, {8'($urandom), st});
    write_reg(CFG_SPEED_PROP_GAIN, kps);
    write_reg(CFG_SPEED_INTEG_GAIN, kis);
    write_reg(CFG_YAW_DERIV_GAIN, kdy);
  endtask

  task automatic send_extremes();
    send_tick(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_tick(mk(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_tick(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_tick(mk(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // defaults: saturation, integral clamp both ways, truncation of small errors
    send_extremes();
    send_tick(mk(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_tick(mk(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
    send_tick(mk(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    send_tick(mk(16'h0100, 16'h0001, 16'hffff, 16'h0000, 16'h0003));
    wait_drained();

    set_gains(16'h7fff, 24'h7fffff, 24'h7fffff, 16'h7fff, 24'h7fffff, 24'h7fffff,
              24'h7fffff);
    send_extremes();
    wait_drained();

    set_gains(16'h8000, 24'h800000, 24'h800000, 16'h8000, 24'h800000, 24'h800000,
              24'h800000);
    send_extremes();
    wait_drained();

    write_reg(CFG_IDX_UNUSED, 24'($urandom));
    send_tick(mk(16'h1234, 16'hfedc, 16'h0042, 16'h8001, 16'h7ffe));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 83; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        set_gains(rand_target(), rand_gain(), rand_gain(), rand_target(), rand_gain(),
                  rand_gain(), rand_gain());
        if ($urandom_range(1) == 0) write_reg(CFG_IDX_UNUSED, 24'($urandom));
        for (int k = 0; k < SEG_TICKS; k++) begin
          send_tick(rand_tick());
          if (k == SEG_TICKS / 2) wait_drained();
        end
        wait_drained();
      end
    end

    stall_pct = 0;
    repeat (40) @(negedge clk);

    $display("run covered %0d control ticks and %0d register writes over four idling phases",
             ticks_sent, reg_writes);
    $display("%0d drive requests checked, %0d failures", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("balance_robot_motor_mixer: match");
    end else begin
      if (pending_count != 0) $error("%0d drive requests never arrived", pending_count);
      $display("balance_robot_motor_mixer: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bmm_pkg.sv
hdl/bmm_cfg_regs.sv
hdl/bmm_datapath.sv
hdl/bmm_ctrl.sv
hdl/balance_robot_motor_mixer.sv
bench/bmm_drive_checker.sv
bench/balance_robot_motor_mixer_tb.sv
